// ===== hw/rtl/hsv_to_xterm256_color_unit_macros.svh =====
// assertion helpers for the hsv to xterm256 color unit
`ifndef HSV_TO_XTERM256_COLOR_UNIT_MACROS_SVH
`define HSV_TO_XTERM256_COLOR_UNIT_MACROS_SVH

// a condition that must hold in the same cycle as its trigger
`define HSVX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsvx same-cycle check failed");

// a condition that must hold in the cycle after its trigger
`define HSVX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsvx next-cycle check failed");

`endif

// ===== hw/rtl/hsvx_pkg.sv =====
`timescale 1ns / 1ps

package hsvx_pkg;

    localparam int NUM_STAGES = 7;

    localparam int HUE_W   = 17;
    localparam int WGT_W   = 9;
    localparam int OFS_W   = 16;
    localparam int K_W     = 11;
    localparam int Q16_W   = 17;
    localparam int W_W     = 14;
    localparam int Y_W     = 20;
    localparam int DIGIT_W = 3;

    localparam logic signed [18:0] HUE_FULL   = 19'sd92160;
    localparam logic [16:0]        HUE_SECTOR = 17'd15360;
    localparam logic [16:0]        HUE_PAIR   = 17'd30720;
    localparam logic [16:0]        HUE_QUAD   = 17'd61440;
    localparam logic [16:0]        SEC_3      = 17'd46080;
    localparam logic [16:0]        SEC_5      = 17'd76800;

    // s and v are 256*k/5 in q1.16, k clamped at the value giving 1.0
    localparam logic [10:0] K_ONE     = 11'd1280;
    localparam logic [10:0] K_S_BASE  = 11'd960;
    localparam logic [10:0] K_V_BASE  = 11'd448;
    localparam logic [8:0]  S_LIM     = 9'd320;
    localparam logic [8:0]  V_LIM     = 9'd277;
    localparam logic [13:0] RECIP5    = 14'd13108;
    // floor(y/15) = y * RECIP15 >> 24, exact for 20-bit y
    localparam logic [20:0] RECIP15   = 21'd1118482;

    localparam logic [2:0] SECT_0 = 3'd0;
    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;
    localparam logic [2:0] SECT_5 = 3'd5;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } t_pipe_ctl;

    function automatic logic [16:0] q16_from_k(input logic [10:0] k);
        logic [24:0] prod;
        logic [8:0]  quo;
        logic [10:0] rem;
        logic [7:0]  frac;
        prod = k * RECIP5;
        quo  = prod[24:16];
        rem  = k - (11'(quo) * 11'd5);
        case (rem[2:0])
            3'd1:    frac = 8'd51;
            3'd2:    frac = 8'd102;
            3'd3:    frac = 8'd153;
            3'd4:    frac = 8'd204;
            default: frac = 8'd0;
        endcase
        return 17'({quo, 8'h00}) + 17'(frac);
    endfunction

    function automatic logic [2:0] div51(input logic [7:0] val);
        logic [2:0] dig;
        if (val == 8'd255)
            dig = 3'd5;
        else if (val >= 8'd204)
            dig = 3'd4;
        else if (val >= 8'd153)
            dig = 3'd3;
        else if (val >= 8'd102)
            dig = 3'd2;
        else if (val >= 8'd51)
            dig = 3'd1;
        else
            dig = 3'd0;
        return dig;
    endfunction

endpackage

// ===== hw/rtl/hsvx_pipe_ctrl.sv =====
`timescale 1ns / 1ps

module hsvx_pipe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    output logic                 o_in_ready,
    output hsvx_pkg::t_pipe_ctl  o_ctl
);

    logic [hsvx_pkg::NUM_STAGES-1:0] r_valid;
    logic [hsvx_pkg::NUM_STAGES-1:0] n_valid;
    logic [hsvx_pkg::NUM_STAGES-1:0] w_ready;

    // a stage takes new data when it is empty or its contents move on
    always_comb begin
        w_ready[hsvx_pkg::NUM_STAGES-1] = !r_valid[hsvx_pkg::NUM_STAGES-1] || i_out_ready;
        for (int k = hsvx_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            w_ready[k] = !r_valid[k] || w_ready[k+1];
        end
        n_valid[0] = w_ready[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < hsvx_pkg::NUM_STAGES; k++) begin
            n_valid[k] = w_ready[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = w_ready[0];
    assign o_ctl.load  = w_ready;
    assign o_ctl.valid = r_valid;

endmodule

// ===== hw/rtl/hsv_to_xterm256_color_unit.sv =====
`timescale 1ns / 1ps

// hsv to xterm 256-color converter. each input transfer carries a hue in 1/256 degree,
// a layer weight and an alpha (both q8); the hue offset register is added and the sum is
// wrapped into 0..360 degrees, saturation and value are formed in q1.16, the six-sector
// hsv color is turned into 8-bit rgb and each channel is quantized by 51 to give the
// cube code 16+36r+6g+b. the datapath is a seven-register pipeline: one item is taken
// every cycle unless the input is blocked by a stall, and each result moves through the stages in order.
// a stalled output only blocks the input once every stage holds an item; empty stages
// keep filling meanwhile. write the hue offset only while no item is in flight.

`include "hsv_to_xterm256_color_unit_macros.svh"

module hsv_to_xterm256_color_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,      // hue_offset
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // hue_in[16:0], layer_weight[25:17], alpha_in[34:26]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // color_code[7:0], red[15:8], green[23:16], blue[31:24]
);

    hsvx_pkg::t_pipe_ctl w_ctl;

    logic signed [15:0] r_hue_offset;

    logic [16:0] w_hue_in;
    logic [8:0]  w_layer;
    logic [8:0]  w_alpha;

    // stage 1: wrapped hue and the k terms of s and v
    logic signed [18:0] n1_hsum;
    logic [16:0]        n1_h;
    logic [10:0]        n1_ks;
    logic [10:0]        n1_kv;
    logic [16:0]        r1_h;
    logic [10:0]        r1_ks;
    logic [10:0]        r1_kv;

    // stage 2: s, v, sector and triangle weight
    logic [16:0] n2_d;
    logic [16:0] n2_dist;
    logic [2:0]  n2_sector;
    logic [16:0] r2_s;
    logic [16:0] r2_v;
    logic [2:0]  r2_sector;
    logic [13:0] r2_w;

    // stage 3: chroma
    logic [33:0] n3_vs;
    logic [16:0] r3_c;
    logic [16:0] r3_v;
    logic [2:0]  r3_sector;
    logic [13:0] r3_w;

    // stage 4: chroma times weight, and m
    logic [30:0] n4_p;
    logic [19:0] r4_y;
    logic [16:0] r4_c;
    logic [16:0] r4_m;
    logic [2:0]  r4_sector;

    // stage 5: x = c*w/15360
    logic [40:0] n5_prod;
    logic [16:0] r5_x;
    logic [16:0] r5_c;
    logic [16:0] r5_m;
    logic [2:0]  r5_sector;

    // stage 6: channel bytes
    logic [16:0] n6_rq;
    logic [16:0] n6_gq;
    logic [16:0] n6_bq;
    logic [16:0] n6_rs;
    logic [16:0] n6_gs;
    logic [16:0] n6_bs;
    logic [24:0] n6_rp;
    logic [24:0] n6_gp;
    logic [24:0] n6_bp;
    logic [7:0]  r6_red;
    logic [7:0]  r6_green;
    logic [7:0]  r6_blue;

    // stage 7: cube code, output register
    logic [8:0] n7_code;
    logic [7:0] r7_code;
    logic [7:0] r7_red;
    logic [7:0] r7_green;
    logic [7:0] r7_blue;

    hsvx_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_ctl       (w_ctl)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_offset <= '0;
        end else if (i_cfg_valid) begin
            r_hue_offset <= $signed(i_cfg_data);
        end
    end

    assign w_hue_in = i_s_axis_tdata[16:0];
    assign w_layer  = i_s_axis_tdata[25:17];
    assign w_alpha  = i_s_axis_tdata[34:26];

    // the sum stays within one turn below zero or above a full turn
    always_comb begin
        n1_hsum = $signed({2'b00, w_hue_in}) + 19'(r_hue_offset);
        if (n1_hsum < 0)
            n1_h = 17'(n1_hsum + hsvx_pkg::HUE_FULL);
        else if (n1_hsum >= hsvx_pkg::HUE_FULL)
            n1_h = 17'(n1_hsum - hsvx_pkg::HUE_FULL);
        else
            n1_h = 17'(n1_hsum);
        n1_ks = (w_layer > hsvx_pkg::S_LIM) ? hsvx_pkg::K_ONE
                                            : hsvx_pkg::K_S_BASE + 11'(w_layer);
        n1_kv = (w_alpha > hsvx_pkg::V_LIM) ? hsvx_pkg::K_ONE
                                            : hsvx_pkg::K_V_BASE + 11'(w_alpha) * 11'd3;
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[0]) begin
            r1_h  <= n1_h;
            r1_ks <= n1_ks;
            r1_kv <= n1_kv;
        end
    end

    always_comb begin
        if (r1_h < hsvx_pkg::HUE_SECTOR)
            n2_sector = hsvx_pkg::SECT_0;
        else if (r1_h < hsvx_pkg::HUE_PAIR)
            n2_sector = hsvx_pkg::SECT_1;
        else if (r1_h < hsvx_pkg::SEC_3)
            n2_sector = hsvx_pkg::SECT_2;
        else if (r1_h < hsvx_pkg::HUE_QUAD)
            n2_sector = hsvx_pkg::SECT_3;
        else if (r1_h < hsvx_pkg::SEC_5)
            n2_sector = hsvx_pkg::SECT_4;
        else
            n2_sector = hsvx_pkg::SECT_5;
        // position inside the current sector pair
        if (r1_h < hsvx_pkg::HUE_PAIR)
            n2_d = r1_h;
        else if (r1_h < hsvx_pkg::HUE_QUAD)
            n2_d = r1_h - hsvx_pkg::HUE_PAIR;
        else
            n2_d = r1_h - hsvx_pkg::HUE_QUAD;
        n2_dist = (n2_d >= hsvx_pkg::HUE_SECTOR) ? n2_d - hsvx_pkg::HUE_SECTOR
                                                 : hsvx_pkg::HUE_SECTOR - n2_d;
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[1]) begin
            r2_s      <= hsvx_pkg::q16_from_k(r1_ks);
            r2_v      <= hsvx_pkg::q16_from_k(r1_kv);
            r2_sector <= n2_sector;
            r2_w      <= 14'(hsvx_pkg::HUE_SECTOR - n2_dist);
        end
    end

    assign n3_vs = r2_v * r2_s;

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[2]) begin
            r3_c      <= n3_vs[32:16];
            r3_v      <= r2_v;
            r3_sector <= r2_sector;
            r3_w      <= r2_w;
        end
    end

    assign n4_p = r3_c * r3_w;

    // divide by 15360 as a shift by 10 here and a divide by 15 in the next stage
    always_ff @(posedge i_clk) begin
        if (w_ctl.load[3]) begin
            r4_y      <= n4_p[29:10];
            r4_c      <= r3_c;
            r4_m      <= r3_v - r3_c;
            r4_sector <= r3_sector;
        end
    end

    assign n5_prod = r4_y * hsvx_pkg::RECIP15;

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[4]) begin
            r5_x      <= n5_prod[40:24];
            r5_c      <= r4_c;
            r5_m      <= r4_m;
            r5_sector <= r4_sector;
        end
    end

    always_comb begin
        case (r5_sector)
            hsvx_pkg::SECT_0: begin
                n6_rq = r5_c;  n6_gq = r5_x;  n6_bq = '0;
            end
            hsvx_pkg::SECT_1: begin
                n6_rq = r5_x;  n6_gq = r5_c;  n6_bq = '0;
            end
            hsvx_pkg::SECT_2: begin
                n6_rq = '0;    n6_gq = r5_c;  n6_bq = r5_x;
            end
            hsvx_pkg::SECT_3: begin
                n6_rq = '0;    n6_gq = r5_x;  n6_bq = r5_c;
            end
            hsvx_pkg::SECT_4: begin
                n6_rq = r5_x;  n6_gq = '0;    n6_bq = r5_c;
            end
            default: begin
                n6_rq = r5_c;  n6_gq = '0;    n6_bq = r5_x;
            end
        endcase
        n6_rs = n6_rq + r5_m;
        n6_gs = n6_gq + r5_m;
        n6_bs = n6_bq + r5_m;
        // times 255 as times 256 minus one
        n6_rp = {n6_rs, 8'h00} - 25'(n6_rs);
        n6_gp = {n6_gs, 8'h00} - 25'(n6_gs);
        n6_bp = {n6_bs, 8'h00} - 25'(n6_bs);
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[5]) begin
            r6_red   <= n6_rp[23:16];
            r6_green <= n6_gp[23:16];
            r6_blue  <= n6_bp[23:16];
        end
    end

    assign n7_code = 9'd16 + 9'd36 * 9'(hsvx_pkg::div51(r6_red))
                   + 9'd6 * 9'(hsvx_pkg::div51(r6_green)) + 9'(hsvx_pkg::div51(r6_blue));

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[6]) begin
            r7_code  <= n7_code[7:0];
            r7_red   <= r6_red;
            r7_green <= r6_green;
            r7_blue  <= r6_blue;
        end
    end

    assign o_m_axis_tvalid = w_ctl.valid[hsvx_pkg::NUM_STAGES-1];
    assign o_m_axis_tdata  = {r7_blue, r7_green, r7_red, r7_code};

    `HSVX_ASSERT_NEXT(a_accept_fills_stage1, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, w_ctl.valid[0])
    `HSVX_ASSERT_SAME(a_full_stall_blocks_input, i_clk, i_rst_n,
        (&w_ctl.valid) && !i_m_axis_tready, !o_s_axis_tready)
    `HSVX_ASSERT_SAME(a_code_in_cube, i_clk, i_rst_n,
        o_m_axis_tvalid, (r7_code >= 8'd16) && (r7_code <= 8'd231))
    `HSVX_ASSERT_SAME(a_chroma_within_value, i_clk, i_rst_n,
        w_ctl.valid[2], r3_c <= r3_v)

endmodule

// ===== tb/tb_hsv_to_xterm256_color_unit.sv =====
`timescale 1ns / 1ps

module tb_hsv_to_xterm256_color_unit;

    localparam longint HUE_TURN  = 92160;
    localparam longint HUE_SIXTH = 15360;
    localparam int     LATENCY   = hsvx_pkg::NUM_STAGES;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     PHASE_ITEMS = 250;
    localparam int     NUM_PHASES  = 8;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;

    logic [31:0]        expected_colors[$];
    logic signed [15:0] hue_offset_model;
    logic [31:0]        want_color;
    logic [15:0]        stall_pat = 16'b1011_0011_1000_1101;
    t_stall_mode        stall_mode;
    bit                 gaps_on;
    int                 burst_left;
    int                 error_count;
    int                 result_count;
    int                 cycle_count;

    hsv_to_xterm256_color_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // packed as {blue, green, red, color_code}
    function automatic logic [31:0] predict_color(input logic [16:0] hue,
                                                  input logic [8:0] lw,
                                                  input logic [8:0] al,
                                                  input logic signed [15:0] ofs);
        longint     hsum, h, s, v, c, x, m, d, tri_dist, rq, gq, bq;
        logic [2:0] sect;
        logic [7:0] r8, g8, b8, code;
        hsum = longint'(hue) + longint'(ofs);
        h = hsum % HUE_TURN;
        if (h < 0)
            h = h + HUE_TURN;
        s = (491520 + 512 * longint'(lw)) / 10;
        if (s > 65536)
            s = 65536;
        v = (229376 + 1536 * longint'(al)) / 10;
        if (v > 65536)
            v = 65536;
        c = (v * s) / 65536;
        sect = 3'(h / HUE_SIXTH);
        d = h % (2 * HUE_SIXTH);
        tri_dist = (d >= HUE_SIXTH) ? (d - HUE_SIXTH) : (HUE_SIXTH - d);
        x = (c * (HUE_SIXTH - tri_dist)) / HUE_SIXTH;
        m = v - c;
        case (sect)
            hsvx_pkg::SECT_0: begin rq = c; gq = x; bq = 0; end
            hsvx_pkg::SECT_1: begin rq = x; gq = c; bq = 0; end
            hsvx_pkg::SECT_2: begin rq = 0; gq = c; bq = x; end
            hsvx_pkg::SECT_3: begin rq = 0; gq = x; bq = c; end
            hsvx_pkg::SECT_4: begin rq = x; gq = 0; bq = c; end
            default:          begin rq = c; gq = 0; bq = x; end
        endcase
        r8 = 8'(((rq + m) * 255) / 65536);
        g8 = 8'(((gq + m) * 255) / 65536);
        b8 = 8'(((bq + m) * 255) / 65536);
        code = 8'(16 + 36 * (r8 / 51) + 6 * (g8 / 51) + b8 / 51);
        return {b8, g8, r8, code};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch in %s at result %0d: got %0d, want %0d",
                     what, result_count, got, want);
    endtask

    // sampled at the falling edge, so the transfer happens at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch("unexpected result", int'(o_m_axis_tdata), 0);
            end else begin
                want_color = expected_colors.pop_front();
                if (o_m_axis_tdata[7:0] !== want_color[7:0])
                    report_mismatch("color_code", o_m_axis_tdata[7:0], want_color[7:0]);
                if (o_m_axis_tdata[15:8] !== want_color[15:8])
                    report_mismatch("red", o_m_axis_tdata[15:8], want_color[15:8]);
                if (o_m_axis_tdata[23:16] !== want_color[23:16])
                    report_mismatch("green", o_m_axis_tdata[23:16], want_color[23:16]);
                if (o_m_axis_tdata[31:24] !== want_color[31:24])
                    report_mismatch("blue", o_m_axis_tdata[31:24], want_color[31:24]);
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        stall_pat <= {stall_pat[14:0], stall_pat[15]};
        case (stall_mode)
            STALL_NONE:   i_m_axis_tready <= 1'b1;
            STALL_RANDOM: i_m_axis_tready <= ($urandom_range(0, 2) != 0);
            default:      i_m_axis_tready <= stall_pat[0];
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // called just after a rising edge; returns at the edge of the transfer
    task automatic send_item(input logic [16:0] hue, input logic [8:0] lw,
                             input logic [8:0] al);
        logic ok;
        int   gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'd0, al, lw, hue};
        do begin
            @(negedge i_clk);
            ok = o_s_axis_tready;
            if (ok)
                expected_colors.push_back(predict_color(hue, lw, al, hue_offset_model));
            @(posedge i_clk);
        end while (!ok);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic signed [15:0] value);
        logic ok;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
        hue_offset_model = value;
    endtask

    // offset still at its reset value: sector borders, full turn and field extremes
    task automatic test_reset_offset();
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
        send_item(17'd0, 9'd0, 9'd0);
        send_item(17'd15359, 9'd256, 9'd256);
        send_item(17'd15360, 9'd128, 9'd200);
        send_item(17'd30719, 9'd256, 9'd0);
        send_item(17'd30720, 9'd0, 9'd256);
        send_item(17'd46080, 9'd511, 9'd511);
        send_item(17'd61440, 9'd300, 9'd100);
        send_item(17'd76800, 9'd64, 9'd400);
        send_item(17'd92159, 9'd256, 9'd256);
        send_item(17'd92160, 9'd100, 9'd150);
        send_item(17'd131071, 9'd511, 9'd0);
        send_item(17'd69120, 9'd257, 9'd277);
    endtask

    // negative sums, sums past a full turn and the extreme offsets of the 16-bit field
    task automatic test_offset_extremes();
        write_offset(-16'sd20480);
        send_item(17'd0, 9'd256, 9'd256);
        send_item(17'd20479, 9'd0, 9'd511);
        write_offset(16'sd20480);
        send_item(17'd92159, 9'd256, 9'd128);
        send_item(17'd71680, 9'd511, 9'd256);
        write_offset(-16'sd32768);
        send_item(17'd0, 9'd200, 9'd200);
        send_item(17'd32767, 9'd256, 9'd0);
        write_offset(16'sd32767);
        send_item(17'd131071, 9'd256, 9'd256);
        send_item(17'd59393, 9'd0, 9'd0);
    endtask

    task automatic test_random_phases();
        logic [16:0]        hue;
        logic [8:0]         lw, al;
        logic signed [15:0] ofs;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       ofs = 16'sd0;
                1:       ofs = -16'sd20480;
                2:       ofs = 16'sd20480;
                5:       ofs = -16'sd32768;
                6:       ofs = 16'sd32767;
                7:       ofs = 16'($urandom);
                default: ofs = 16'($urandom_range(0, 40960) - 20480);
            endcase
            write_offset(ofs);
            gaps_on = (phase % 4) != 0;
            case (phase % 3)
                0:       stall_mode = STALL_NONE;
                1:       stall_mode = STALL_RANDOM;
                default: stall_mode = STALL_PATTERN;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                hue = ($urandom_range(0, 9) == 0) ? 17'($urandom)
                                                  : 17'($urandom_range(0, 92159));
                lw  = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256));
                al  = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256));
                send_item(hue, lw, al);
            end
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_data       <= 16'd0;
        i_s_axis_tvalid  <= 1'b0;
        i_s_axis_tdata   <= 40'd0;
        stall_mode       = STALL_NONE;
        gaps_on          = 1'b0;
        burst_left       = 0;
        hue_offset_model = 16'sd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_offset();
        test_offset_extremes();
        test_random_phases();

        wait_idle();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
